FILE: src/nfbp_pkg.sv
// ----------------------------------------------------------------------------
// nfbp_pkg
// Shared types and constants of the next-fit two-resource bin packer.
// ----------------------------------------------------------------------------
package nfbp_pkg;

  localparam int SUM_W          = 25;
  localparam int BIN_W          = 10;
  localparam int JOB_NUM_W      = 10;
  localparam int DEMAND_FIELD_W = 16;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  localparam logic [SUM_W-1:0] CAPACITY_RESET = SUM_W'(65535);

  // Command codes carried in the cmd field.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  // Register selects, taken from paddr bit 2 (byte address 4*i).
  localparam logic REG_CPU_CAPACITY = 1'b0;
  localparam logic REG_MEM_CAPACITY = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [JOB_NUM_W-1:0]      job_number;
    logic [DEMAND_FIELD_W-1:0] run_time;
    logic [DEMAND_FIELD_W-1:0] mem_need;
    logic [DEMAND_FIELD_W-1:0] cpu_need;
    logic                      last_of_order;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_number;
    logic             is_final;
    logic [SUM_W-1:0] makespan;
    logic [BIN_W-1:0] bins_used;
  } out_item_t;

endpackage

FILE: src/nfbp_job_table.sv
// ----------------------------------------------------------------------------
// nfbp_job_table
// Single-port job record memory with a registered read.
// ----------------------------------------------------------------------------
module nfbp_job_table #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 48
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wr_data,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: src/next_fit_two_resource_bin_packer_unit.sv
// ----------------------------------------------------------------------------
// next_fit_two_resource_bin_packer_unit
// A place transaction is read from the job table at the edge that accepts it,
//   held in the read stage, and its result is loaded into the output register
//   once that register is free or being emptied; it stays valid until taken.
// Throughput: one transaction per cycle unless the result channel stalls, set by
//   the single job table port and the one add-compare pass that updates the bin sums.
// Reset: synchronous, active high; sums clear, bin counter goes to one and
//   both capacities to 65535. Job table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module next_fit_two_resource_bin_packer_unit
  import nfbp_pkg::*;
#(
  parameter int TABLE_DEPTH = 512,
  parameter int DEMAND_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int NUM_W = IDX_W > JOB_NUM_W ? IDX_W : JOB_NUM_W;
  // Stored demand width: the fields are masked to DEMAND_BITS, and they never
  // carry more than the 16 bits of the input field.
  localparam int DW    = DEMAND_BITS < DEMAND_FIELD_W ? DEMAND_BITS : DEMAND_FIELD_W;
  localparam int REC_W = 3 * DW;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never waits, and a read returns the
  // selected capacity zero extended to the bus width.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] cpu_capacity;
  logic [SUM_W-1:0] mem_capacity;
  logic             cfg_write;
  logic             reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_capacity <= CAPACITY_RESET;
      mem_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CPU_CAPACITY: cpu_capacity <= pwdata[SUM_W-1:0];
        REG_MEM_CAPACITY: mem_capacity <= pwdata[SUM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CPU_CAPACITY: prdata = APB_DATA_W'(cpu_capacity);
      REG_MEM_CAPACITY: prdata = APB_DATA_W'(mem_capacity);
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side. The job table is written or read at the very edge at which a
  // transaction is accepted, so a place that follows a load of the same job
  // in the next cycle already sees the new record.
  // --------------------------------------------------------------------------
  logic             in_accept;
  logic             in_range;
  logic [NUM_W-1:0] num_ext;
  logic [IDX_W-1:0] table_idx;
  logic [REC_W-1:0] wr_rec;
  logic [REC_W-1:0] rd_rec;
  logic             tbl_wr_en;
  logic             tbl_rd_en;

  assign in_accept = in_valid && !in_stall;
  assign num_ext   = NUM_W'(in_item.job_number) - NUM_W'(1);
  assign table_idx = num_ext[IDX_W-1:0];
  assign in_range  = (in_item.job_number != '0) &&
                     (32'(in_item.job_number) <= 32'(TABLE_DEPTH));
  assign wr_rec    = {in_item.run_time[DW-1:0], in_item.mem_need[DW-1:0],
                      in_item.cpu_need[DW-1:0]};
  assign tbl_wr_en = in_accept && (in_item.cmd == CMD_LOAD) && in_range;
  assign tbl_rd_en = in_accept && (in_item.cmd == CMD_PLACE);

  nfbp_job_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (REC_W)
  ) u_job_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .rd_en   (tbl_rd_en),
    .addr    (table_idx),
    .wr_data (wr_rec),
    .rd_data (rd_rec)
  );

  // --------------------------------------------------------------------------
  // Read stage. It holds the transaction while the table data comes out. A
  // load has nothing left to do here and always retires; a place retires
  // when the output register is free or being emptied in the same cycle.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_cmd;
  logic s1_last;
  logic s1_in_range;
  logic s1_retire;
  logic place_fire;

  assign s1_retire  = s1_valid && ((s1_cmd == CMD_LOAD) || !out_valid || !out_stall);
  assign place_fire = s1_retire && (s1_cmd == CMD_PLACE);
  assign in_stall   = s1_valid && !s1_retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd      <= in_item.cmd;
      s1_last     <= in_item.last_of_order;
      s1_in_range <= in_range;
    end
  end

  // --------------------------------------------------------------------------
  // Packing stage. A job with an out-of-range number counts as zero time and
  // zero demand. When either sum would pass its capacity a new bin opens and
  // the job starts it alone, even if it is too big for any bin.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] mem_sum;
  logic [SUM_W-1:0] cpu_sum;
  logic [SUM_W-1:0] time_sum;
  logic [SUM_W-1:0] longest_time;
  logic [BIN_W-1:0] bin_counter;

  logic [SUM_W-1:0] job_time;
  logic [SUM_W-1:0] job_mem;
  logic [SUM_W-1:0] job_cpu;
  logic [SUM_W:0]   mem_try;
  logic [SUM_W:0]   cpu_try;
  logic [SUM_W:0]   time_try;
  logic             no_fit;
  logic [SUM_W-1:0] mem_sum_next;
  logic [SUM_W-1:0] cpu_sum_next;
  logic [SUM_W-1:0] time_sum_next;
  logic [SUM_W-1:0] longest_time_next;
  logic [BIN_W-1:0] bin_counter_next;

  always_comb begin
    if (s1_in_range) begin
      job_time = SUM_W'(rd_rec[3*DW-1:2*DW]);
      job_mem  = SUM_W'(rd_rec[2*DW-1:DW]);
      job_cpu  = SUM_W'(rd_rec[DW-1:0]);
    end else begin
      job_time = '0;
      job_mem  = '0;
      job_cpu  = '0;
    end
  end

  assign mem_try  = {1'b0, mem_sum} + {1'b0, job_mem};
  assign cpu_try  = {1'b0, cpu_sum} + {1'b0, job_cpu};
  assign time_try = {1'b0, time_sum} + {1'b0, job_time};
  assign no_fit   = (mem_try > {1'b0, mem_capacity}) || (cpu_try > {1'b0, cpu_capacity});

  always_comb begin
    if (no_fit) begin
      mem_sum_next  = job_mem;
      cpu_sum_next  = job_cpu;
      time_sum_next = job_time;
      if (bin_counter != BIN_MAX) begin
        bin_counter_next = bin_counter + BIN_W'(1);
      end else begin
        bin_counter_next = bin_counter;
      end
    end else begin
      mem_sum_next     = mem_try[SUM_W-1:0];
      cpu_sum_next     = cpu_try[SUM_W-1:0];
      // Run-time totals saturate rather than wrap.
      time_sum_next    = time_try[SUM_W] ? SUM_MAX : time_try[SUM_W-1:0];
      bin_counter_next = bin_counter;
    end
    longest_time_next = (time_sum_next > longest_time) ? time_sum_next : longest_time;
  end

  // The sums clear after the last job of an ordering so that the next
  // ordering starts with bin one and nothing in it.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_sum      <= '0;
      cpu_sum      <= '0;
      time_sum     <= '0;
      longest_time <= '0;
      bin_counter  <= BIN_W'(1);
    end else if (place_fire) begin
      if (s1_last) begin
        mem_sum      <= '0;
        cpu_sum      <= '0;
        time_sum     <= '0;
        longest_time <= '0;
        bin_counter  <= BIN_W'(1);
      end else begin
        mem_sum      <= mem_sum_next;
        cpu_sum      <= cpu_sum_next;
        time_sum     <= time_sum_next;
        longest_time <= longest_time_next;
        bin_counter  <= bin_counter_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It holds a result while the receiver stalls, and the
  // read stage keeps accepting as long as it has room.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (place_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (place_fire) begin
      out_item.bin_number <= bin_counter_next;
      out_item.is_final   <= s1_last;
      out_item.makespan   <= s1_last ? longest_time_next : '0;
      out_item.bins_used  <= s1_last ? bin_counter_next : '0;
    end
  end

`ifndef SYNTHESIS
  a_final_count_matches : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_final |-> out_item.bins_used == out_item.bin_number)
    else $error("final result bin count differs from its bin number");

  a_partial_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.is_final |-> out_item.makespan == '0 &&
                                        out_item.bins_used == '0)
    else $error("non-final result carries makespan or bin count");

  a_longest_covers_current : assert property (@(posedge clk) disable iff (rst)
    longest_time >= time_sum)
    else $error("longest bin time fell below the current bin time");

  a_clear_after_final : assert property (@(posedge clk) disable iff (rst)
    place_fire && s1_last |=> bin_counter == BIN_W'(1) && time_sum == '0 &&
                              mem_sum == '0 && cpu_sum == '0)
    else $error("sums not cleared after the end of an ordering");

  a_bin_counter_nonzero : assert property (@(posedge clk) disable iff (rst)
    bin_counter != '0)
    else $error("bin counter reached zero");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the next-fit two-resource bin packer. Job
// records are loaded into the table, orderings of job numbers are placed, and
// every result transaction is compared field by field against a next-fit
// prediction kept in the bench. Both channels idle and stall at random, and
// the two bin capacities are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import nfbp_pkg::*;

  localparam int JOB_SLOTS     = 512;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [JOB_NUM_W-1:0] JOB_NUM_MAX = {JOB_NUM_W{1'b1}};

  // One row of the job table as the bench keeps it.
  typedef struct packed {
    logic [DEMAND_FIELD_W-1:0] run_time;
    logic [DEMAND_FIELD_W-1:0] mem_need;
    logic [DEMAND_FIELD_W-1:0] cpu_need;
  } job_entry_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  next_fit_two_resource_bin_packer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the packer state. It advances once per accepted input
  // transaction, so it always describes the block as of the last acceptance.
  // --------------------------------------------------------------------------
  job_entry_t       job_store [JOB_SLOTS];
  bit               job_loaded [JOB_SLOTS];
  int               loaded_jobs [$];   // one-based numbers of entries holding data
  logic [SUM_W-1:0] mem_sum, cpu_sum, time_sum, longest_time;
  logic [BIN_W-1:0] bin_count;
  logic [SUM_W-1:0] cpu_cap = CAPACITY_RESET;
  logic [SUM_W-1:0] mem_cap = CAPACITY_RESET;

  // Placement results still owed by the block, oldest first.
  out_item_t awaited_placements [$];

  int          mismatches      = 0;
  int          loads_accepted  = 0;
  int          places_accepted = 0;
  int          results_seen    = 0;
  int          orders_closed   = 0;
  int          capacity_writes = 0;
  int unsigned cycle_count     = 0;

  // Idling switches; the random phase flips them so that some stretches run
  // back to back with no gaps at all.
  bit          input_gaps_on    = 1'b1;
  bit          result_stalls_on = 1'b1;
  int unsigned stall_left       = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic clear_bin_sums();
    mem_sum      = '0;
    cpu_sum      = '0;
    time_sum     = '0;
    longest_time = '0;
    bin_count    = BIN_W'(1);
  endtask

  // Next-fit step: a load writes a table row; a place adds the named job to
  // the open bin or opens a new one when either resource would overflow.
  task automatic pack_next_fit(input in_item_t item);
    job_entry_t          job;
    logic [SUM_W:0]      mem_try, cpu_try, time_try;
    out_item_t           res;
    bit                  in_range;
    in_range = item.job_number >= 1 && item.job_number <= JOB_SLOTS;
    if (item.cmd == CMD_LOAD) begin
      loads_accepted++;
      if (in_range) begin
        job_store[item.job_number - 1] = '{item.run_time, item.mem_need, item.cpu_need};
        if (!job_loaded[item.job_number - 1]) begin
          job_loaded[item.job_number - 1] = 1'b1;
          loaded_jobs.push_back(int'(item.job_number));
        end
      end
      return;
    end
    places_accepted++;
    // An out-of-range number places a job with no time and no demand.
    job = '0;
    if (in_range)
      job = job_store[item.job_number - 1];
    mem_try = {1'b0, mem_sum} + job.mem_need;
    cpu_try = {1'b0, cpu_sum} + job.cpu_need;
    if (mem_try > {1'b0, mem_cap} || cpu_try > {1'b0, cpu_cap}) begin
      // The job opens a fresh bin even when it alone is oversized.
      if (bin_count != BIN_MAX)
        bin_count++;
      mem_sum  = SUM_W'(job.mem_need);
      cpu_sum  = SUM_W'(job.cpu_need);
      time_sum = SUM_W'(job.run_time);
    end else begin
      mem_sum  = mem_try[SUM_W-1:0];
      cpu_sum  = cpu_try[SUM_W-1:0];
      time_try = {1'b0, time_sum} + job.run_time;
      time_sum = (time_try > {1'b0, SUM_MAX}) ? SUM_MAX : time_try[SUM_W-1:0];
    end
    if (time_sum > longest_time)
      longest_time = time_sum;
    res            = '0;
    res.bin_number = bin_count;
    if (item.last_of_order) begin
      res.is_final  = 1'b1;
      res.makespan  = longest_time;
      res.bins_used = bin_count;
      orders_closed++;
      clear_bin_sums();
    end
    awaited_placements.push_back(res);
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic logic [DEMAND_FIELD_W-1:0] rand_demand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DEMAND_FIELD_W'($urandom_range(0, 255));
      5, 6, 7: return DEMAND_FIELD_W'($urandom_range(0, 16383));
      default: return DEMAND_FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_item_t make_item(input logic cmd, input int num,
                                         input int run, input int mem, input int cpu,
                                         input logic last);
    in_item_t item;
    item.cmd           = cmd;
    item.job_number    = JOB_NUM_W'(num);
    item.run_time      = DEMAND_FIELD_W'(run);
    item.mem_need      = DEMAND_FIELD_W'(mem);
    item.cpu_need      = DEMAND_FIELD_W'(cpu);
    item.last_of_order = last;
    return item;
  endfunction

  function automatic int out_of_range_job();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(JOB_SLOTS + 1, int'(JOB_NUM_MAX));
  endfunction

  function automatic in_item_t random_load();
    int num;
    num = ($urandom_range(0, 9) == 0) ? out_of_range_job() : $urandom_range(1, JOB_SLOTS);
    return make_item(CMD_LOAD, num, rand_demand(), rand_demand(), rand_demand(),
                     1'($urandom_range(0, 1)));
  endfunction

  // Places only entries that have been loaded; the demand fields are junk.
  function automatic in_item_t random_place(input logic last);
    return make_item(CMD_PLACE, loaded_jobs[$urandom_range(0, loaded_jobs.size() - 1)],
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), last);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call. Valid stays high after acceptance
  // until the next falling edge, where it is either reloaded or dropped.
  // --------------------------------------------------------------------------
  task automatic push_transaction(input in_item_t item);
    int gap;
    gap = input_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pack_next_fit(item);
  endtask

  // Drops valid and waits until every owed result has come back, then lets
  // the pipeline settle so that a trailing load has surely been absorbed.
  task automatic drain_results();
    int waited;
    @(negedge clk);
    in_valid = 1'b0;
    waited   = 0;
    while (awaited_placements.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_placements.size() != 0) begin
      report_mismatch("results never delivered", 0, awaited_placements.size());
      awaited_placements.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: setup phase, then access phase until pready.
  // --------------------------------------------------------------------------
  task automatic apb_transfer(input logic write, input logic reg_sel,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = APB_ADDR_W'({reg_sel, 2'b00});
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_capacity(input logic reg_sel, input logic [SUM_W-1:0] kept);
    logic [APB_DATA_W-1:0] readback;
    apb_transfer(1'b0, reg_sel, '0, readback);
    if (readback !== APB_DATA_W'(kept))
      report_mismatch(reg_sel == REG_CPU_CAPACITY ? "cpu_capacity readback"
                                                  : "mem_capacity readback",
                      readback, kept);
  endtask

  // Upper data bits carry random junk; the register keeps only its width.
  task automatic set_capacity(input logic reg_sel, input logic [SUM_W-1:0] kept);
    logic [APB_DATA_W-1:0] value, unused;
    value            = $urandom();
    value[SUM_W-1:0] = kept;
    apb_transfer(1'b1, reg_sel, value, unused);
    if (reg_sel == REG_CPU_CAPACITY)
      cpu_cap = kept;
    else
      mem_cap = kept;
    capacity_writes++;
    check_capacity(reg_sel, kept);
  endtask

  task automatic set_capacities(input logic [SUM_W-1:0] cpu, input logic [SUM_W-1:0] mem);
    set_capacity(REG_CPU_CAPACITY, cpu);
    set_capacity(REG_MEM_CAPACITY, mem);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, and a checker at every rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (result_stalls_on && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_placements.size() == 0) begin
        report_mismatch("result with nothing awaited, bin_number", out_item.bin_number, 0);
      end else begin
        want = awaited_placements.pop_front();
        if (out_item.bin_number !== want.bin_number)
          report_mismatch("bin_number", out_item.bin_number, want.bin_number);
        if (out_item.is_final !== want.is_final)
          report_mismatch("is_final", out_item.is_final, want.is_final);
        if (out_item.makespan !== want.makespan)
          report_mismatch("makespan", out_item.makespan, want.makespan);
        if (out_item.bins_used !== want.bins_used)
          report_mismatch("bins_used", out_item.bins_used, want.bins_used);
      end
    end
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("next_fit_two_resource_bin_packer_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset capacities, demand extremes, out-of-range numbers on both commands,
  // and an end mark on a load, which must be ignored.
  task automatic test_reset_and_extremes();
    check_capacity(REG_CPU_CAPACITY, CAPACITY_RESET);
    check_capacity(REG_MEM_CAPACITY, CAPACITY_RESET);
    push_transaction(make_item(CMD_LOAD, 1, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_LOAD, JOB_SLOTS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    push_transaction(make_item(CMD_LOAD, 2, 16'h1234, 16'h8000, 16'h0100, 1'b0));
    // Loads outside the table must leave everything untouched.
    push_transaction(make_item(CMD_LOAD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    push_transaction(make_item(CMD_LOAD, JOB_SLOTS + 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    push_transaction(make_item(CMD_LOAD, JOB_NUM_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    // The full-demand job exactly fills bin 1; job 2 then spills to bin 2.
    push_transaction(make_item(CMD_PLACE, JOB_SLOTS, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 1, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    push_transaction(make_item(CMD_PLACE, 0, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, JOB_NUM_MAX, 0, 0, 0, 1'b1));
    // Two halves of memory overflow by one; two single-job orderings follow.
    push_transaction(make_item(CMD_PLACE, 2, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 2, 0, 0, 0, 1'b1));
    push_transaction(make_item(CMD_PLACE, JOB_SLOTS, 0, 0, 0, 1'b1));
    push_transaction(make_item(CMD_PLACE, JOB_SLOTS + 1, 0, 0, 0, 1'b1));
    drain_results();
  endtask

  // A job bigger than a bin still gets a bin of its own; when it comes first
  // the ordering starts at bin 2 and bin 1 stays empty.
  task automatic test_oversized_jobs();
    set_capacities(SUM_W'(1000), SUM_W'(5000));
    push_transaction(make_item(CMD_LOAD, 10, 7, 100, 5000, 1'b0));
    push_transaction(make_item(CMD_LOAD, 11, 3, 200, 300, 1'b0));
    push_transaction(make_item(CMD_PLACE, 10, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 11, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 11, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 10, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 11, 0, 0, 0, 1'b1));
    drain_results();
  endtask

  // Enough full-length jobs in one bin to drive the time total into its limit,
  // then a short ordering to see that the sums were cleared.
  task automatic test_time_saturation();
    set_capacities(CAPACITY_RESET, CAPACITY_RESET);
    push_transaction(make_item(CMD_LOAD, 20, 16'hFFFF, 0, 0, 1'b0));
    for (int i = 0; i < 520; i++)
      push_transaction(make_item(CMD_PLACE, 20, 0, 0, 0, 1'(i == 519)));
    push_transaction(make_item(CMD_PLACE, 20, 0, 0, 0, 1'b0));
    push_transaction(make_item(CMD_PLACE, 20, 0, 0, 0, 1'b1));
    drain_results();
  endtask

  // Zero capacities force a new bin for every job until the counter sticks.
  task automatic test_bin_saturation();
    set_capacities('0, '0);
    push_transaction(make_item(CMD_LOAD, 21, 1, 1, 1, 1'b0));
    for (int i = 0; i < 1030; i++)
      push_transaction(make_item(CMD_PLACE, 21, 0, 0, 0, 1'(i == 1029)));
    drain_results();
  endtask

  // Mostly well-formed orderings over loaded jobs, with stray loads and
  // out-of-range places mixed in.
  task automatic run_random_phase(input int budget);
    int sent, len;
    sent = 0;
    repeat (24) begin
      push_transaction(random_load());
      sent++;
    end
    while (sent < budget) begin
      input_gaps_on    = $urandom_range(0, 3) != 0;
      result_stalls_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0: begin
          push_transaction(random_load());
          sent++;
        end
        1: begin
          push_transaction(make_item(CMD_PLACE, out_of_range_job(), $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                                     1'($urandom_range(0, 1))));
          sent++;
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
              push_transaction(random_load());
              sent++;
            end
            push_transaction(random_place(1'(i == len - 1)));
            sent++;
          end
        end
      endcase
    end
    input_gaps_on    = 1'b1;
    result_stalls_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_orderings();
    set_capacities(CAPACITY_RESET, CAPACITY_RESET);
    run_random_phase(220);
    set_capacities(SUM_W'($urandom_range(30000, 200000)), SUM_W'($urandom_range(30000, 200000)));
    run_random_phase(220);
    // Everything fits one bin per ordering.
    set_capacities(SUM_MAX, SUM_MAX);
    run_random_phase(220);
    // Only jobs with no CPU demand can share a bin.
    set_capacities('0, SUM_W'($urandom_range(1000, 70000)));
    run_random_phase(220);
    set_capacities(SUM_W'($urandom_range(1000, 70000)), SUM_W'($urandom_range(1000, 70000)));
    run_random_phase(220);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_bin_sums();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_and_extremes();
    test_oversized_jobs();
    test_time_saturation();
    test_bin_saturation();
    test_random_orderings();
    drain_results();

    $display("Covered %0d loads and %0d places; %0d results checked, %0d orderings closed.",
             loads_accepted, places_accepted, results_seen, orders_closed);
    $display("Capacity writes: %0d, cycles: %0d, mismatches: %0d.",
             capacity_writes, cycle_count, mismatches);
    if (mismatches == 0)
      $display("next_fit_two_resource_bin_packer_unit regression: pass");
    else
      $display("next_fit_two_resource_bin_packer_unit regression: fail");
    $finish;
  end

endmodule
